// File: rtl/lot_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU order tracker package
// Shared widths, operation and status codes, controller states and the
// command and plan words that pass between controller and datapath.
// ----------------------------------------------------------------------------
package lot_pkg;

   localparam int ENTRIES_DEFAULT    = 64;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int OP_W     = 3;
   localparam int HANDLE_W = 6;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 3;
   localparam int LENGTH_W = 7;

   typedef enum logic [OP_W-1:0] {
      OP_NEW_HEAD = 3'd0,
      OP_TOUCH    = 3'd1,
      OP_POP_TAIL = 3'd2,
      OP_DESTROY  = 3'd3,
      OP_GET_DATA = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK         = 3'd0,
      STAT_FULL       = 3'd1,
      STAT_EMPTY      = 3'd2,
      STAT_BAD_HANDLE = 3'd3,
      STAT_NOT_LISTED = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UNLINK,
      ST_LINK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic read;
      logic unlink;
      logic link;
   } cmd_type;

   typedef struct packed {
      logic unlink;
      logic link;
      logic fill;
   } plan_type;

endpackage
`default_nettype wire

// File: rtl/lru_order_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU order tracker
// Keeps slot handles in recency order as a doubly linked list in memories.
// ----------------------------------------------------------------------------
// A command word (req_op, req_handle, req_entry_data) is taken at a rising
// edge where start is high and busy is low. Busy stays high until the result
// word has been shown. Each command gives one result word (rsp_status,
// rsp_result_handle, rsp_result_data, rsp_length), held for exactly one cycle
// while rsp_strobe is high; the receiver must take it then.
// After acceptance a command passes through a read step (registered reads of
// the link memories), an unlink and a link step that write them, and the
// result cycle: unlink for move to head, pop tail and listed destroy, link
// for new head and move to head, neither for get data, errors and unlisted
// destroy. The next command may be taken in the cycle after the strobe.
// Reset empties the list and frees every slot at once; no clearing pass is
// needed, and a command may be issued in the first cycle after reset.
// ----------------------------------------------------------------------------
module lru_order_tracker #(
   parameter int ENTRIES    = lot_pkg::ENTRIES_DEFAULT,
   parameter int DATA_WIDTH = lot_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [lot_pkg::OP_W-1:0]     req_op,
   input  wire logic [lot_pkg::HANDLE_W-1:0] req_handle,
   input  wire logic [lot_pkg::DATA_W-1:0]   req_entry_data,
   output logic                              rsp_strobe,
   output logic [lot_pkg::STATUS_W-1:0]      rsp_status,
   output logic [lot_pkg::HANDLE_W-1:0]      rsp_result_handle,
   output logic [lot_pkg::DATA_W-1:0]        rsp_result_data,
   output logic [lot_pkg::LENGTH_W-1:0]      rsp_length
);
   import lot_pkg::*;

   cmd_type  cmd;
   plan_type plan;

   lot_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .plan       (plan),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   lot_datapath #(.ENTRIES(ENTRIES), .DATA_WIDTH(DATA_WIDTH)) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .plan              (plan),
      .req_op            (req_op),
      .req_handle        (req_handle),
      .req_entry_data    (req_entry_data),
      .rsp_status        (rsp_status),
      .rsp_result_handle (rsp_result_handle),
      .rsp_result_data   (rsp_result_data),
      .rsp_length        (rsp_length)
   );

endmodule
`default_nettype wire

// File: rtl/lot_free_finder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU order tracker free slot finder
// Two registered levels of priority encoding that track the lowest free slot.
// ----------------------------------------------------------------------------
module lot_free_finder #(
   parameter int ENTRIES = lot_pkg::ENTRIES_DEFAULT,
   parameter int SW      = 6
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [ENTRIES-1:0] alloc,
   output logic                    free_any,
   output logic [SW-1:0]           free_idx
);
   import lot_pkg::*;

   localparam int GROUPS = (ENTRIES + 7) / 8;

   logic [GROUPS-1:0] grp_any_ff, grp_any_in;
   logic [2:0]        grp_idx_ff [GROUPS];
   logic [2:0]        grp_idx_in [GROUPS];
   logic              free_any_ff, free_any_in;
   logic [SW-1:0]     free_idx_ff, free_idx_in;

   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_any_in[g] = 1'b0;
         grp_idx_in[g] = '0;
         for (int b = 7; b >= 0; b--) begin
            if (g * 8 + b < ENTRIES) begin
               if (!alloc[g * 8 + b]) begin
                  grp_any_in[g] = 1'b1;
                  grp_idx_in[g] = 3'(b);
               end
            end
         end
      end
   end

   always_comb begin
      free_any_in = 1'b0;
      free_idx_in = '0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            free_any_in = 1'b1;
            free_idx_in = SW'(g * 8 + int'(grp_idx_ff[g]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_any_ff  <= '1;
         free_any_ff <= 1'b1;
         free_idx_ff <= '0;
         for (int g = 0; g < GROUPS; g++) begin
            grp_idx_ff[g] <= '0;
         end
      end else begin
         grp_any_ff  <= grp_any_in;
         free_any_ff <= free_any_in;
         free_idx_ff <= free_idx_in;
         for (int g = 0; g < GROUPS; g++) begin
            grp_idx_ff[g] <= grp_idx_in[g];
         end
      end
   end

   assign free_any = free_any_ff;
   assign free_idx = free_idx_ff;

endmodule
`default_nettype wire

// File: rtl/lot_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU order tracker datapath
// Link and data memories, slot flags, head, tail and count, and result words.
// ----------------------------------------------------------------------------
module lot_datapath #(
   parameter int ENTRIES    = lot_pkg::ENTRIES_DEFAULT,
   parameter int DATA_WIDTH = lot_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire lot_pkg::cmd_type                cmd,
   output lot_pkg::plan_type                    plan,
   input  wire logic [lot_pkg::OP_W-1:0]        req_op,
   input  wire logic [lot_pkg::HANDLE_W-1:0]    req_handle,
   input  wire logic [lot_pkg::DATA_W-1:0]      req_entry_data,
   output logic [lot_pkg::STATUS_W-1:0]         rsp_status,
   output logic [lot_pkg::HANDLE_W-1:0]         rsp_result_handle,
   output logic [lot_pkg::DATA_W-1:0]           rsp_result_data,
   output logic [lot_pkg::LENGTH_W-1:0]         rsp_length
);
   import lot_pkg::*;

   localparam int SW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);

   logic [SW-1:0]         prev_mem [ENTRIES];
   logic [SW-1:0]         next_mem [ENTRIES];
   logic [DATA_WIDTH-1:0] data_mem [ENTRIES];

   logic [SW-1:0]         rd_prev_ff, rd_next_ff;
   logic [DATA_WIDTH-1:0] rd_data_ff;

   logic [ENTRIES-1:0]    alloc_ff, alloc_in;
   logic [ENTRIES-1:0]    listed_ff, listed_in;
   logic [SW-1:0]         head_ff, head_in;
   logic [SW-1:0]         tail_ff, tail_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [SW-1:0]         slot_ff, slot_in;
   logic [DATA_W-1:0]     data_ff, data_in;
   status_type            status_ff, status_in;
   logic                  show_handle_ff, show_handle_in;
   logic                  show_data_ff, show_data_in;
   plan_type              plan_ff, plan_in;

   logic                  free_any;
   logic [SW-1:0]         free_idx;
   logic [SW-1:0]         h_slot;
   logic                  h_valid;

   lot_free_finder #(.ENTRIES(ENTRIES), .SW(SW)) u_free_finder (
      .clock    (clock),
      .reset    (reset),
      .alloc    (alloc_ff),
      .free_any (free_any),
      .free_idx (free_idx)
   );

   assign h_slot  = SW'(req_handle);
   assign h_valid = (int'(req_handle) < ENTRIES) && alloc_ff[h_slot];

   always_comb begin
      alloc_in       = alloc_ff;
      listed_in      = listed_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      slot_in        = slot_ff;
      data_in        = data_ff;
      status_in      = status_ff;
      show_handle_in = show_handle_ff;
      show_data_in   = show_data_ff;
      plan_in        = plan_ff;
      if (cmd.accept) begin
         data_in        = req_entry_data;
         status_in      = STAT_OK;
         show_handle_in = 1'b0;
         show_data_in   = 1'b0;
         plan_in        = '0;
         case (req_op)
            OP_NEW_HEAD: begin
               if (!free_any) begin
                  status_in = STAT_FULL;
               end else begin
                  slot_in           = free_idx;
                  alloc_in[free_idx] = 1'b1;
                  plan_in.link      = 1'b1;
                  plan_in.fill      = 1'b1;
                  show_handle_in    = 1'b1;
               end
            end
            OP_TOUCH: begin
               if (!h_valid) begin
                  status_in = STAT_BAD_HANDLE;
               end else if (!listed_ff[h_slot]) begin
                  status_in = STAT_NOT_LISTED;
               end else begin
                  slot_in        = h_slot;
                  plan_in.unlink = 1'b1;
                  plan_in.link   = 1'b1;
               end
            end
            OP_POP_TAIL: begin
               if (count_ff == '0) begin
                  status_in = STAT_EMPTY;
               end else begin
                  slot_in        = tail_ff;
                  plan_in.unlink = 1'b1;
                  show_handle_in = 1'b1;
                  show_data_in   = 1'b1;
               end
            end
            OP_DESTROY: begin
               if (!h_valid) begin
                  status_in = STAT_BAD_HANDLE;
               end else begin
                  slot_in          = h_slot;
                  plan_in.unlink   = listed_ff[h_slot];
                  alloc_in[h_slot] = 1'b0;
               end
            end
            OP_GET_DATA: begin
               if (!h_valid) begin
                  status_in = STAT_BAD_HANDLE;
               end else begin
                  slot_in      = h_slot;
                  show_data_in = 1'b1;
               end
            end
            default: begin
               status_in = STAT_OK;
            end
         endcase
      end
      if (cmd.unlink) begin
         if (slot_ff == head_ff) begin
            head_in = rd_next_ff;
         end
         if (slot_ff == tail_ff) begin
            tail_in = rd_prev_ff;
         end
         listed_in[slot_ff] = 1'b0;
         count_in           = count_ff - 1'b1;
      end
      if (cmd.link) begin
         if (count_ff == '0) begin
            tail_in = slot_ff;
         end
         head_in            = slot_ff;
         listed_in[slot_ff] = 1'b1;
         count_in           = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff  <= '0;
         listed_ff <= '0;
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
         plan_ff   <= '0;
      end else begin
         alloc_ff  <= alloc_in;
         listed_ff <= listed_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         plan_ff   <= plan_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff        <= slot_in;
      data_ff        <= data_in;
      status_ff      <= status_in;
      show_handle_ff <= show_handle_in;
      show_data_ff   <= show_data_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_prev_ff <= prev_mem[slot_ff];
         rd_next_ff <= next_mem[slot_ff];
         rd_data_ff <= data_mem[slot_ff];
      end
      if (cmd.unlink) begin
         if (slot_ff != head_ff) begin
            next_mem[rd_prev_ff] <= rd_next_ff;
         end
         if (slot_ff != tail_ff) begin
            prev_mem[rd_next_ff] <= rd_prev_ff;
         end
      end
      if (cmd.link) begin
         next_mem[slot_ff] <= head_ff;
         if (count_ff != '0) begin
            prev_mem[head_ff] <= slot_ff;
         end
         if (plan_ff.fill) begin
            data_mem[slot_ff] <= DATA_WIDTH'(data_ff);
         end
      end
   end

   assign plan              = plan_ff;
   assign rsp_status        = status_ff;
   assign rsp_result_handle = show_handle_ff ? HANDLE_W'(slot_ff) : '0;
   assign rsp_result_data   = show_data_ff ? DATA_W'(rd_data_ff) : '0;
   assign rsp_length        = LENGTH_W'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= ENTRIES)
      else $error("list count exceeds the slot count");

   a_count_matches_listed: assert property (@(posedge clock) disable iff (reset)
      $countones(listed_ff) == int'(count_ff))
      else $error("list count disagrees with the listed slots");

   a_fill_with_link: assert property (@(posedge clock) disable iff (reset)
      plan_ff.fill |-> plan_ff.link)
      else $error("data fill planned without a link step");

endmodule
`default_nettype wire

// File: rtl/lot_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU order tracker controller
// Sequences read, unlink, link and result steps for one command at a time.
// ----------------------------------------------------------------------------
module lot_controller (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire lot_pkg::plan_type plan,
   output lot_pkg::cmd_type       cmd,
   output logic                   busy,
   output logic                   rsp_strobe
);
   import lot_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (plan.unlink) begin
               state_in = ST_UNLINK;
            end else if (plan.link) begin
               state_in = ST_LINK;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_UNLINK: begin
            state_in = plan.link ? ST_LINK : ST_DONE;
         end
         ST_LINK: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy       = 1'b0;
            cmd.accept = start;
         end
         ST_READ: begin
            cmd.read = 1'b1;
         end
         ST_UNLINK: begin
            cmd.unlink = 1'b1;
         end
         ST_LINK: begin
            cmd.link = 1'b1;
         end
         ST_DONE: begin
            rsp_strobe = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> state_ff == ST_READ)
      else $error("accepted word did not go to the read step");

   a_link_then_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LINK |=> rsp_strobe)
      else $error("link step not followed by the result");

   a_done_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy)
      else $error("result not followed by idle");

endmodule
`default_nettype wire
